// ----- hdl/assert_macros.svh -----
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, checked out of reset
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ----- hdl/mst_pkg.sv -----
// Shared types, constants and arithmetic helpers of the slot tracker.
`timescale 1ns / 1ps
package mst_pkg;

    localparam int MAX_SLOTS = 16;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = 5;
    localparam int TS_W      = 63;
    localparam int NUM_W     = 47;
    localparam int DEN_W     = 64;
    localparam logic [30:0] NS2 = 31'd2000000000;  // 2 * ns per second

    typedef enum logic [2:0] {
        OP_SELECT = 3'd0,
        OP_TRACK  = 3'd1,
        OP_POS_X  = 3'd2,
        OP_POS_Y  = 3'd3,
        OP_FRAME  = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        KIND_ALIVE = 2'd0,
        KIND_SET   = 2'd1,
        KIND_FSEQ  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        CFG_X_OFFSET   = 3'd0,
        CFG_Y_OFFSET   = 3'd1,
        CFG_X_SCALE    = 3'd2,
        CFG_Y_SCALE    = 3'd3,
        CFG_SLOT_COUNT = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [31:0]        session;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [31:0]        speed_x;
        logic [31:0]        speed_y;
        logic [TS_W-1:0]    time_x;
        logic [TS_W-1:0]    time_y;
        logic               changed;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{session: '1, default: '0};

    // floor((sign*prod) / 2^17), saturated to Q1.15
    function automatic logic signed [15:0] norm_sat(input logic neg, input logic [63:0] prod);
        logic [64:0] rnd;
        logic [47:0] q;
        begin
            rnd = {1'b0, prod} + 65'h1FFFF;
            q   = rnd[64:17];
            if (!neg) begin
                norm_sat = (prod[63:17] > 47'd32767) ? 16'sh7FFF : prod[32:17];
            end else begin
                norm_sat = (q > 48'd32768) ? 16'sh8000 : 16'(~q[15:0] + 16'd1);
            end
        end
    endfunction

    // signed speed from magnitude quotient, saturated to 32 bits
    function automatic logic [31:0] sat_speed(input logic neg, input logic [NUM_W-1:0] q);
        begin
            if (!neg) begin
                sat_speed = (q > NUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
            end else begin
                sat_speed = (q >= NUM_W'(33'h8000_0000)) ? 32'h8000_0000
                                                         : (~q[31:0] + 32'd1);
            end
        end
    endfunction

endpackage

// ----- hdl/multitouch_slot_tracker_top.sv -----
// Top level of the multitouch slot tracker: event sequencer, slot memory, outputs.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Touch events enter one at a time. Select-slot and ignored events finish in
// the idle state. A tracking-id event reads the slot and writes it back; an
// X or Y position event reads, multiplies, normalises, scales the step, runs
// a radix-2 divide of the position step by the time step and writes back,
// skipping the divide when the position did not move or the time step is
// zero. A frame report walks the active slots twice, reading then evaluating
// each slot, and waits whenever the result side stalls. The contact table
// sits in one 16-entry memory with registered read; entries never written
// read as free slots through a per-entry valid flag cleared at reset. Config
// writes are always accepted and must only be made while the block is idle.
module multitouch_slot_tracker_top (
    input  logic         aclk,
    input  logic         aresetn,
    // events
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // event_value[31:0], timestamp_ns[94:32], zero pad
    input  logic [2:0]   s_tuser,   // opcode
    // records
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,   // session_id, pos_x, pos_y, speed_x, speed_y, frame_number
    output logic [1:0]   m_tuser,   // record_kind
    output logic         m_tlast,
    // configuration writes
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_MUL, ST_NORM, ST_MUL2, ST_DIV_GO, ST_DIV_WAIT, ST_WB,
        ST_SC1_RD, ST_SC1_EV, ST_SC2_RD, ST_SC2_EV, ST_FRAME
    } state_t;

    localparam int SW = mst_pkg::SLOT_W;
    localparam int CW = mst_pkg::CNT_W;

    state_t state_reg;

    // configuration
    logic [31:0]   x_off_reg, y_off_reg, x_scale_reg, y_scale_reg;
    logic [CW-1:0] slot_count_reg;

    // sequencer state
    logic [31:0]                 cur_slot_reg;
    logic [31:0]                 frame_cnt_reg;
    mst_pkg::op_t                op_reg;
    logic [31:0]                 val_reg;
    logic [mst_pkg::TS_W-1:0]    t_reg;
    logic [SW-1:0]               addr_reg;
    logic                        neg_reg;
    logic [63:0]                 prod_reg;
    logic signed [15:0]          pos_reg;
    logic                        dneg_reg;
    logic [15:0]                 dmag_reg;
    logic [mst_pkg::DEN_W-1:0]   dt_reg;
    logic [mst_pkg::NUM_W-1:0]   num_reg;
    logic [31:0]                 speed_reg;

    // slot memory
    mst_pkg::entry_t             mem [mst_pkg::MAX_SLOTS];
    logic [mst_pkg::MAX_SLOTS-1:0] vld_reg;
    mst_pkg::entry_t             rd_q_reg;
    logic                        rd_vld_reg;
    mst_pkg::entry_t             ent;
    mst_pkg::entry_t             wr_data;
    logic                        mem_we;

    // output register
    logic         m_tvalid_reg;
    logic [159:0] m_tdata_reg;
    logic [1:0]   m_tuser_reg;
    logic         m_tlast_reg;

    // combinational helpers
    logic [CW-1:0]       active;
    logic                occupied;
    logic                out_free;
    logic                out_load;
    logic                scan_last;
    logic                in_range;
    logic                accept;
    logic [32:0]         diff;
    logic [32:0]         mag;
    logic [31:0]         scale;
    logic signed [15:0]  pos_new;
    logic signed [15:0]  prev_pos;
    logic [mst_pkg::TS_W-1:0] prev_t;
    logic [16:0]         delta;
    logic                div_start;
    logic                div_done;
    logic [mst_pkg::NUM_W-1:0] div_quot;

    assign active    = (slot_count_reg > CW'(mst_pkg::MAX_SLOTS)) ? CW'(mst_pkg::MAX_SLOTS)
                                                                : slot_count_reg;
    assign ent       = rd_vld_reg ? rd_q_reg : mst_pkg::ENTRY_RESET;
    assign occupied  = ent.session != 32'hFFFF_FFFF;
    assign out_free  = !m_tvalid_reg || m_tready;
    // a record enters the output register this cycle
    assign out_load  = out_free && (((state_reg == ST_SC1_EV) && occupied)
                                    || ((state_reg == ST_SC2_EV) && occupied && ent.changed)
                                    || (state_reg == ST_FRAME));
    assign scan_last = (CW'(addr_reg) + CW'(1)) == active;
    assign in_range  = cur_slot_reg < 32'(active);
    assign s_tready  = state_reg == ST_IDLE;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign div_start = state_reg == ST_DIV_GO;

    always_comb begin
        if (op_reg == mst_pkg::OP_POS_X) begin
            diff     = {val_reg[31], val_reg} - {x_off_reg[31], x_off_reg};
            scale    = x_scale_reg;
            prev_pos = ent.pos_x;
            prev_t   = ent.time_x;
        end else begin
            diff     = {val_reg[31], val_reg} - {y_off_reg[31], y_off_reg};
            scale    = y_scale_reg;
            prev_pos = ent.pos_y;
            prev_t   = ent.time_y;
        end
        mag     = diff[32] ? (~diff + 33'd1) : diff;
        pos_new = mst_pkg::norm_sat(neg_reg, prod_reg);
        delta   = {pos_new[15], pos_new} - {prev_pos[15], prev_pos};
    end

    // write-back data and enable
    always_comb begin
        wr_data = ent;
        mem_we  = 1'b0;
        if (state_reg == ST_WB) begin
            mem_we = 1'b1;
            case (op_reg)
                mst_pkg::OP_TRACK: wr_data.session = val_reg;
                mst_pkg::OP_POS_X: begin
                    wr_data.pos_x   = pos_reg;
                    wr_data.speed_x = speed_reg;
                    wr_data.time_x  = t_reg;
                    wr_data.changed = 1'b1;
                end
                default: begin
                    wr_data.pos_y   = pos_reg;
                    wr_data.speed_y = speed_reg;
                    wr_data.time_y  = t_reg;
                    wr_data.changed = 1'b1;
                end
            endcase
        end else if (state_reg == ST_SC2_EV && occupied && ent.changed && out_free) begin
            mem_we          = 1'b1;
            wr_data.changed = 1'b0;
        end
    end

    // slot memory, registered read
    always_ff @(posedge aclk) begin
        rd_q_reg <= mem[addr_reg];
        if (mem_we) begin
            mem[addr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= vld_reg[addr_reg];
            if (mem_we) begin
                vld_reg[addr_reg] <= 1'b1;
            end
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_off_reg      <= '0;
            y_off_reg      <= '0;
            x_scale_reg    <= 32'd65536;
            y_scale_reg    <= 32'd65536;
            slot_count_reg <= CW'(8);
        end else if (cfg_valid && cfg_ready) begin
            unique case (mst_pkg::cfg_idx_t'(cfg_index))
                mst_pkg::CFG_X_OFFSET:   x_off_reg      <= cfg_data;
                mst_pkg::CFG_Y_OFFSET:   y_off_reg      <= cfg_data;
                mst_pkg::CFG_X_SCALE:    x_scale_reg    <= cfg_data;
                mst_pkg::CFG_Y_SCALE:    y_scale_reg    <= cfg_data;
                mst_pkg::CFG_SLOT_COUNT: slot_count_reg <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    mst_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_reg),
        .den     (dt_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cur_slot_reg  <= '0;
            frame_cnt_reg <= '0;
            m_tvalid_reg  <= 1'b0;
            addr_reg      <= '0;
            op_reg        <= mst_pkg::OP_SELECT;
        end else begin
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        op_reg  <= mst_pkg::op_t'(s_tuser);
                        val_reg <= s_tdata[31:0];
                        t_reg   <= s_tdata[94:32];
                        unique case (mst_pkg::op_t'(s_tuser))
                            mst_pkg::OP_SELECT: cur_slot_reg <= s_tdata[31:0];
                            mst_pkg::OP_TRACK, mst_pkg::OP_POS_X, mst_pkg::OP_POS_Y: begin
                                if (in_range) begin
                                    addr_reg  <= cur_slot_reg[SW-1:0];
                                    state_reg <= ST_RD;
                                end
                            end
                            mst_pkg::OP_FRAME: begin
                                if (frame_cnt_reg == '0) begin
                                    frame_cnt_reg <= 32'd1;
                                end else if (active == '0) begin
                                    state_reg <= ST_FRAME;
                                end else begin
                                    addr_reg  <= '0;
                                    state_reg <= ST_SC1_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_RD: begin
                    state_reg <= (op_reg == mst_pkg::OP_TRACK) ? ST_WB : ST_MUL;
                end
                ST_MUL: begin
                    neg_reg   <= diff[32];
                    prod_reg  <= {31'd0, mag} * {32'd0, scale};
                    state_reg <= ST_NORM;
                end
                ST_NORM: begin
                    pos_reg   <= pos_new;
                    dneg_reg  <= delta[16];
                    dmag_reg  <= delta[16] ? 16'(~delta + 17'd1) : delta[15:0];
                    dt_reg    <= {1'b0, t_reg} - {1'b0, prev_t};
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    num_reg <= mst_pkg::NUM_W'(dmag_reg) * mst_pkg::NUM_W'(mst_pkg::NS2);
                    if (dmag_reg == '0) begin
                        speed_reg <= '0;
                        state_reg <= ST_WB;
                    end else if (dt_reg == '0) begin
                        speed_reg <= mst_pkg::sat_speed(dneg_reg, '1);
                        state_reg <= ST_WB;
                    end else begin
                        state_reg <= ST_DIV_GO;
                    end
                end
                ST_DIV_GO: state_reg <= ST_DIV_WAIT;
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        speed_reg <= mst_pkg::sat_speed(dneg_reg, div_quot);
                        state_reg <= ST_WB;
                    end
                end
                ST_WB: state_reg <= ST_IDLE;
                ST_SC1_RD: state_reg <= ST_SC1_EV;
                ST_SC1_EV: begin
                    if (!occupied || out_free) begin
                        if (occupied) begin
                            m_tuser_reg  <= mst_pkg::KIND_ALIVE;
                            m_tlast_reg  <= 1'b0;
                            m_tdata_reg  <= {128'd0, ent.session};
                        end
                        if (scan_last) begin
                            addr_reg  <= '0;
                            state_reg <= ST_SC2_RD;
                        end else begin
                            addr_reg  <= addr_reg + SW'(1);
                            state_reg <= ST_SC1_RD;
                        end
                    end
                end
                ST_SC2_RD: state_reg <= ST_SC2_EV;
                ST_SC2_EV: begin
                    if (!(occupied && ent.changed) || out_free) begin
                        if (occupied && ent.changed) begin
                            m_tuser_reg  <= mst_pkg::KIND_SET;
                            m_tlast_reg  <= 1'b0;
                            m_tdata_reg  <= {32'd0, ent.speed_y, ent.speed_x,
                                             ent.pos_y, ent.pos_x, ent.session};
                        end
                        if (scan_last) begin
                            state_reg <= ST_FRAME;
                        end else begin
                            addr_reg  <= addr_reg + SW'(1);
                            state_reg <= ST_SC2_RD;
                        end
                    end
                end
                ST_FRAME: begin
                    if (out_free) begin
                        m_tuser_reg   <= mst_pkg::KIND_FSEQ;
                        m_tlast_reg   <= 1'b1;
                        m_tdata_reg   <= {frame_cnt_reg, 128'd0};
                        frame_cnt_reg <= frame_cnt_reg + 32'd1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    `ASSERT_IMP(a_div_nonzero, aclk, aresetn, div_start, dt_reg != '0)
    `ASSERT_IMP(a_we_in_range, aclk, aresetn, mem_we, (CW'(addr_reg) < active))
    `ASSERT_NXT(a_frame_last, aclk, aresetn, (state_reg == ST_FRAME) && out_free,
                m_tvalid_reg && m_tlast_reg)

endmodule

// ----- hdl/mst_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module mst_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [mst_pkg::NUM_W-1:0] num,
    input  logic [mst_pkg::DEN_W-1:0] den,
    output logic                      done,
    output logic [mst_pkg::NUM_W-1:0] quot
);

    localparam int CW = $clog2(mst_pkg::NUM_W);

    logic                      busy_reg;
    logic                      done_reg;
    logic [CW-1:0]             cnt_reg;
    logic [mst_pkg::DEN_W-1:0] rem_reg;
    logic [mst_pkg::DEN_W-1:0] den_reg;
    logic [mst_pkg::NUM_W-1:0] quo_reg;
    logic [mst_pkg::DEN_W:0]   shifted;
    logic                      ge;

    assign shifted = {rem_reg, quo_reg[mst_pkg::NUM_W-1]};
    assign ge      = shifted >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !start && busy_reg && (cnt_reg == '0);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(mst_pkg::NUM_W - 1);
                rem_reg  <= '0;
                den_reg  <= den;
                quo_reg  <= num;
            end else if (busy_reg) begin
                rem_reg <= ge ? mst_pkg::DEN_W'(shifted - {1'b0, den_reg})
                              : shifted[mst_pkg::DEN_W-1:0];
                quo_reg <= {quo_reg[mst_pkg::NUM_W-2:0], ge};
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                end else begin
                    cnt_reg <= cnt_reg - CW'(1);
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule
